[rtl/http_payload_extractor_defines.svh]
// Assertion macros shared by the extractor RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef HTTP_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define HTTP_PAYLOAD_EXTRACTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HPX_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpx: implication check failed");

// antecedent implies consequent in the next cycle
`define HPX_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hpx: next-cycle check failed");

// invariant
`define HPX_ASSERT_ALWAYS(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("hpx: invariant check failed");

`endif

[rtl/hpx_pkg.sv]
// Shared types, constants and match functions for the HTTP payload extractor.
// No dependencies.
package hpx_pkg;

	localparam int POS_W            = 16;
	localparam int MAX_FRAME_BYTES  = 65536;
	localparam int ETH_HEADER_BYTES = 14;
	localparam int WIN_DEPTH        = 8;
	localparam int CMD_BYTES        = WIN_DEPTH + 1;
	localparam int WIN_BITS         = CMD_BYTES * 8;
	localparam int CMD_DEPTH        = 4;

	localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
	localparam logic [15:0] MIN_IP_LEN   = 16'd11;

	// frame positions
	localparam logic [POS_W-1:0] POS_ETYPE_HI = POS_W'(12);
	localparam logic [POS_W-1:0] POS_ETYPE_LO = POS_W'(13);
	localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(ETH_HEADER_BYTES + 2);
	localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(ETH_HEADER_BYTES + 3);
	localparam logic [POS_W-1:0] POS_PROTO    = POS_W'(ETH_HEADER_BYTES + 9);
	localparam logic [POS_W-1:0] POS_IP_START = POS_W'(ETH_HEADER_BYTES);

	// IP byte indexes
	localparam logic [POS_W-1:0] IPN_HELD    = POS_W'(WIN_DEPTH);
	localparam logic [POS_W-1:0] IPN_RELEASE = POS_W'(WIN_DEPTH + 1);

	localparam logic [23:0] KW_GET  = "GET";
	localparam logic [31:0] KW_POST = "POST";
	localparam logic [63:0] KW_HTTP = "HTTP/1.1";

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_req_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_last;
	} payload_req_t;

	// one entry of the front-to-back queue: bytes emitted in order where mask is set
	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] data;
		logic [CMD_BYTES-1:0]      mask;
		logic                      last;
	} hpx_cmd_t;

	function automatic logic get_at(logic [WIN_BITS-1:0] w, int unsigned i);
		return {w[8*i +: 8], w[8*(i+1) +: 8], w[8*(i+2) +: 8]} == KW_GET;
	endfunction

	function automatic logic post_at(logic [WIN_BITS-1:0] w, int unsigned i);
		return {w[8*i +: 8], w[8*(i+1) +: 8], w[8*(i+2) +: 8], w[8*(i+3) +: 8]} == KW_POST;
	endfunction

	function automatic logic http_at0(logic [WIN_BITS-1:0] w);
		logic [63:0] s;
		for (int k = 0; k < 8; k++) begin
			s[63-8*k -: 8] = w[8*k +: 8];
		end
		return s == KW_HTTP;
	endfunction

endpackage

[rtl/hpx_front.sv]
// Front end: frame filter, IP length tracking, lookahead window and keyword match.
// Uses hpx_pkg; pushes one queue entry per accepted byte that yields output.
`include "http_payload_extractor_defines.svh"

module hpx_front import hpx_pkg::*; #(
	parameter int MAX_FRAME_BYTES = hpx_pkg::MAX_FRAME_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  frame_req_t frame,
	output logic       push,
	output hpx_cmd_t   cmd
);

	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FRAME_BYTES - 1);

	logic [POS_W-1:0] pos_q;
	logic             ipv4_q;
	logic [15:0]      ip_len_q;
	logic             done_q;
	logic             kw_q;
	logic [3:0]       fill_q;
	logic [7:0]       held_q;
	logic [7:0]       win_q [WIN_DEPTH];

	logic                 end_here, ipv4_n, drop, active, ip_end, win_full;
	logic                 at_held, at_release;
	logic [15:0]          len_n;
	logic [POS_W-1:0]     ipn;
	logic [WIN_BITS-1:0]  w;
	logic [CMD_BYTES-1:0] m, kw;
	logic [7:0]           b;

	always_comb begin
		b        = frame.frame_byte;
		end_here = frame.frame_last || (pos_q == POS_LIMIT);
		ipv4_n   = ipv4_q;
		len_n    = ip_len_q;
		drop     = 1'b0;
		if (pos_q == POS_ETYPE_HI) begin
			ipv4_n = (b == ETYPE_IPV4[15:8]);
		end
		if (pos_q == POS_ETYPE_LO) begin
			ipv4_n = ipv4_q && (b == ETYPE_IPV4[7:0]);
			drop   = !ipv4_n;
		end
		if (pos_q == POS_LEN_HI) begin
			len_n = {b, 8'h00};
		end
		if (pos_q == POS_LEN_LO) begin
			len_n = {ip_len_q[15:8], b};
			drop  = len_n < MIN_IP_LEN;
		end
		if (pos_q == POS_PROTO && b != IP_PROTO_TCP) begin
			drop = 1'b1;
		end
		// frame ending before the filter is decided
		if (end_here && pos_q <= POS_PROTO) begin
			drop = 1'b1;
		end

		active     = !done_q && !drop && (pos_q >= POS_IP_START);
		ipn        = pos_q - POS_IP_START;
		ip_end     = end_here ||
			((ipn > IPN_RELEASE - POS_W'(1)) && ({1'b0, ipn} + 17'd1 == {1'b0, ip_len_q}));
		win_full   = (fill_q == 4'(WIN_DEPTH));
		at_held    = (ipn == IPN_HELD);
		at_release = (ipn == IPN_RELEASE);

		for (int i = 0; i < WIN_DEPTH; i++) begin
			w[8*i +: 8] = win_q[i];
		end
		w[8*WIN_DEPTH +: 8] = b;

		// a pattern counts only if a further byte is in the buffer
		m = '0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			if (i <= CMD_BYTES - 4) m[i] = m[i] | get_at(w, i);
			if (i <= CMD_BYTES - 5) m[i] = m[i] | post_at(w, i);
		end
		m[0] = m[0] | http_at0(w);

		kw[0] = kw_q || m[0];
		for (int i = 1; i < CMD_BYTES; i++) begin
			kw[i] = kw[i-1] || m[i];
		end

		cmd.data = w;
		cmd.last = ip_end;
		for (int i = 2; i < CMD_BYTES; i++) begin
			cmd.mask[i] = ip_end && kw[i];
		end
		if (at_release) begin
			// IP byte 0 was held until the protocol byte passed
			cmd.data[0] = held_q;
			cmd.data[1] = w[7:0];
			cmd.mask[0] = kw_q;
			cmd.mask[1] = kw[0];
		end else begin
			cmd.mask[0] = !at_held && kw[0];
			cmd.mask[1] = ip_end && kw[1];
		end

		push = in_fire && active && win_full && (cmd.mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			ipv4_q   <= 1'b0;
			ip_len_q <= '0;
			done_q   <= 1'b0;
			kw_q     <= 1'b0;
			fill_q   <= '0;
		end else if (in_fire) begin
			if (frame.frame_last) begin
				pos_q    <= '0;
				ipv4_q   <= 1'b0;
				ip_len_q <= '0;
				done_q   <= 1'b0;
				kw_q     <= 1'b0;
				fill_q   <= '0;
			end else if (!done_q) begin
				ipv4_q   <= ipv4_n;
				ip_len_q <= len_n;
				if (drop || (active && ip_end)) begin
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (active && !ip_end) begin
					if (!win_full) begin
						fill_q <= fill_q + 4'd1;
					end else begin
						kw_q <= kw[0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && active && !ip_end) begin
			for (int i = 0; i < WIN_DEPTH - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[WIN_DEPTH-1] <= b;
			if (win_full && at_held) begin
				held_q <= win_q[0];
			end
		end
	end

	`HPX_ASSERT_NEXT(a_last_clears, in_fire && frame.frame_last, pos_q == '0 && !done_q && !kw_q)
	`HPX_ASSERT_IMP(a_push_full_win, push, win_full && !done_q)

endmodule

[rtl/hpx_cmd_fifo.sv]
// Short queue of emit requests between front and back ends.
// Uses hpx_pkg for the entry type.
`include "http_payload_extractor_defines.svh"

module hpx_cmd_fifo import hpx_pkg::*; #(
	parameter int DEPTH = hpx_pkg::CMD_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  hpx_cmd_t wr_cmd,
	input  logic     pop,
	output hpx_cmd_t rd_cmd,
	output logic     valid,
	output logic     full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hpx_cmd_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign valid   = (count_q != '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rd_cmd  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	`HPX_ASSERT_IMP(a_no_overflow, push, !full)
	`HPX_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH))

endmodule

[rtl/hpx_back.sv]
// Back end: walks the mask of each queued request and sends one byte per cycle while ready.
// Uses hpx_pkg; output register decouples it from the downstream ready.
`include "http_payload_extractor_defines.svh"

module hpx_back import hpx_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  hpx_cmd_t     cmd,
	input  logic         cmd_valid,
	output logic         pop,
	output payload_req_t payload,
	output logic         payload_valid,
	input  logic         payload_ready
);

	logic [CMD_BYTES-1:0]      cur_mask_q;
	logic [CMD_BYTES-1:0][7:0] cur_data_q;
	logic                      cur_last_q;
	payload_req_t              payload_q;
	logic                      payload_valid_q;

	logic [CMD_BYTES-1:0] pick, rest;
	logic [7:0]           pick_byte;
	logic                 out_load;

	always_comb begin
		pick      = cur_mask_q & (~cur_mask_q + CMD_BYTES'(1));
		rest      = cur_mask_q & ~pick;
		pick_byte = '0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			if (pick[i]) pick_byte = pick_byte | cur_data_q[i];
		end
		out_load = (cur_mask_q != '0) && (!payload_valid_q || payload_ready);
		// refill as the current request sends its final byte
		pop      = cmd_valid && ((cur_mask_q == '0) || (out_load && rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q      <= '0;
			payload_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_mask_q <= cmd.mask;
			end else if (out_load) begin
				cur_mask_q <= rest;
			end
			if (out_load) begin
				payload_valid_q <= 1'b1;
			end else if (payload_ready) begin
				payload_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_data_q <= cmd.data;
			cur_last_q <= cmd.last;
		end
		if (out_load) begin
			payload_q.payload_byte <= pick_byte;
			payload_q.payload_last <= cur_last_q && (rest == '0);
		end
	end

	assign payload       = payload_q;
	assign payload_valid = payload_valid_q;

	`HPX_ASSERT_IMP(a_pick_onehot, out_load, $onehot(pick))
	`HPX_ASSERT_NEXT(a_load_shows, out_load, payload_valid_q)

endmodule

[rtl/http_payload_extractor.sv]
// HTTP payload extractor: takes an Ethernet frame one byte per cycle and, for
// IPv4/TCP frames, sends every IP byte from the first GET, POST or HTTP/1.1
// (followed by at least one more IP byte) to the end of the IP packet. Input
// runs at one byte per cycle; output bytes trail the input by the 8-byte
// lookahead window, and the window flush at the end of a packet sends up to
// nine bytes from one input byte, one per cycle, out of the back end. A
// CMD_DEPTH-entry request queue absorbs those bursts; frame_ready drops only
// while it is full, so with payload_ready high the sustained rate is one byte
// per cycle. Uses hpx_pkg.

module http_payload_extractor import hpx_pkg::*; #(
	parameter int MAX_FRAME_BYTES = hpx_pkg::MAX_FRAME_BYTES,
	parameter int CMD_DEPTH       = hpx_pkg::CMD_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         frame_valid,
	output logic         frame_ready,
	input  frame_req_t   frame,
	output logic         payload_valid,
	input  logic         payload_ready,
	output payload_req_t payload
);

	logic     in_fire, push, pop, q_valid, q_full;
	hpx_cmd_t push_cmd, head_cmd;

	assign frame_ready = !q_full;
	assign in_fire     = frame_valid && frame_ready;

	hpx_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_fire(in_fire),
		.frame  (frame),
		.push   (push),
		.cmd    (push_cmd)
	);

	hpx_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(push_cmd),
		.pop   (pop),
		.rd_cmd(head_cmd),
		.valid (q_valid),
		.full  (q_full)
	);

	hpx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head_cmd),
		.cmd_valid    (q_valid),
		.pop          (pop),
		.payload      (payload),
		.payload_valid(payload_valid),
		.payload_ready(payload_ready)
	);

endmodule
